/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk and masked during reset.
`define PSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in this cycle implies a result in the next cycle.
`define PSL_ASSERT_NEXT(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) else $error(msg);

`endif

/* hw/rtl/psl_pkg.sv */
// Package: types, constants and control/status bundles of the positional list.
package psl_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int DATA_W   = 32;
	localparam int LEN_W    = 7;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [1:0] {
		FN_GET    = 2'd0,
		FN_INSERT = 2'd1,
		FN_DELETE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_DRAIN,
		ST_WVAL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic get_read;
		logic step;
		logic write_val;
		logic finish;
	} cmd_t;

	typedef struct packed {
		func_t in_func;
		logic  in_ok;
		logic  in_shift;
		func_t req_func;
		logic  last;
		logic  out_free;
	} status_t;

endpackage

/* hw/rtl/positional_sequence_list_top.sv */
// Top level of the positional list: controller plus datapath.
//
//   channel | valid     | stall     | beat fields
//   in      | in_valid  | in_stall  | func, position, value
//   out     | out_valid | out_stall | ok, read_value, length
//
// One request at a time. Get, clear and any failed request go straight to result load;
// insert shifts the entries from the position up, then writes the value (no shift when
// appending); delete shifts the entries above the position down (none at the tail); one entry
// moved per cycle through the entry memory (one read and one write per cycle).
// arst_n clears the count and control; entries are not cleared.
// A stalled result is held in the output register; the next beat is taken
// once the controller is back in idle.
module positional_sequence_list_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        func,
	input  logic [psl_pkg::POS_W-1:0]         position,
	input  logic signed [psl_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              ok,
	output logic signed [psl_pkg::DATA_W-1:0] read_value,
	output logic [psl_pkg::LEN_W-1:0]         length
);

	psl_pkg::cmd_t    cmd;
	psl_pkg::status_t st;

	psl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	psl_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (func),
		.position   (position),
		.value      (value),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.ok         (ok),
		.read_value (read_value),
		.length     (length),
		.cmd        (cmd),
		.st         (st)
	);

endmodule

/* hw/rtl/psl_ctrl.sv */
// Controller: sequences capture, entry shifting, value write and result load.
module psl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  psl_pkg::status_t st,
	output psl_pkg::cmd_t    cmd
);

	psl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			psl_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture  = 1'b1;
					cmd.get_read = (st.in_func == psl_pkg::FN_GET);
					unique case (st.in_func)
						psl_pkg::FN_INSERT: begin
							if (!st.in_ok)
								state_d = psl_pkg::ST_FINISH;
							else if (st.in_shift)
								state_d = psl_pkg::ST_SHIFT;
							else
								state_d = psl_pkg::ST_WVAL;
						end
						psl_pkg::FN_DELETE: begin
							state_d = (st.in_ok && st.in_shift) ? psl_pkg::ST_SHIFT
								: psl_pkg::ST_FINISH;
						end
						default: state_d = psl_pkg::ST_FINISH;
					endcase
				end
			end
			psl_pkg::ST_SHIFT: begin
				cmd.step = 1'b1;
				if (st.last)
					state_d = psl_pkg::ST_DRAIN;
			end
			psl_pkg::ST_DRAIN: begin
				// last shifted entry is written back this cycle
				state_d = (st.req_func == psl_pkg::FN_INSERT) ? psl_pkg::ST_WVAL
					: psl_pkg::ST_FINISH;
			end
			psl_pkg::ST_WVAL: begin
				cmd.write_val = 1'b1;
				state_d       = psl_pkg::ST_FINISH;
			end
			psl_pkg::ST_FINISH: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = psl_pkg::ST_IDLE;
				end
			end
			default: state_d = psl_pkg::ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/psl_dpath.sv */
// Datapath: entry memory, count, request registers, shift pipeline, result register.
module psl_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [1:0]                           func,
	input  logic [psl_pkg::POS_W-1:0]            position,
	input  logic signed [psl_pkg::DATA_W-1:0]    value,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic                                 ok,
	output logic signed [psl_pkg::DATA_W-1:0]    read_value,
	output logic [psl_pkg::LEN_W-1:0]            length,
	input  psl_pkg::cmd_t                        cmd,
	output psl_pkg::status_t                     st
);

	logic [psl_pkg::DATA_W-1:0] entries_q [psl_pkg::CAPACITY];

	logic [psl_pkg::CNT_W-1:0]  count_q, count_d, cnt_m1;
	psl_pkg::func_t             in_func, func_q;
	logic [psl_pkg::POS_W-1:0]  pos_m1;
	logic [psl_pkg::CMP_W-1:0]  pos_w, cnt_w;
	logic                       pos_zero, in_ok, in_shift;
	logic                       ok_req_q, pos_zero_q;
	logic [psl_pkg::IDX_W-1:0]  pos_idx_q, k_q, rd_addr;
	logic [psl_pkg::DATA_W-1:0] val_q, rdata_q;
	logic                       rd_en;
	logic                       wpend_s1;
	logic [psl_pkg::IDX_W-1:0]  waddr_s1;
	logic                       out_valid_q, ok_q;
	logic [psl_pkg::DATA_W-1:0] read_value_q;
	logic [psl_pkg::LEN_W-1:0]  length_q;

	// Decode of the beat on the input port against the current count
	assign in_func  = psl_pkg::func_t'(func);
	assign pos_m1   = position - psl_pkg::POS_W'(1);
	assign cnt_m1   = count_q - psl_pkg::CNT_W'(1);
	assign pos_w    = psl_pkg::CMP_W'(position);
	assign cnt_w    = psl_pkg::CMP_W'(count_q);
	assign pos_zero = (position == '0);

	always_comb begin
		in_ok    = 1'b0;
		in_shift = 1'b0;
		unique case (in_func)
			psl_pkg::FN_GET: begin
				in_ok = pos_zero || (pos_w <= cnt_w);
			end
			psl_pkg::FN_INSERT: begin
				in_ok    = !pos_zero && (pos_w <= cnt_w + psl_pkg::CMP_W'(1))
					&& (cnt_w < psl_pkg::CMP_W'(psl_pkg::CAPACITY));
				in_shift = (pos_w <= cnt_w);
			end
			psl_pkg::FN_DELETE: begin
				in_ok    = !pos_zero && (pos_w <= cnt_w);
				in_shift = (pos_w < cnt_w);
			end
			psl_pkg::FN_CLEAR: begin
				in_ok = 1'b1;
			end
			default: in_ok = 1'b0;
		endcase
	end

	// Request registers and shift index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q <= psl_pkg::FN_GET;
		end else if (cmd.capture) begin
			func_q <= in_func;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ok_req_q   <= in_ok;
			pos_zero_q <= pos_zero;
			pos_idx_q  <= psl_pkg::IDX_W'(pos_m1);
			val_q      <= value;
			// insert walks down from the top entry, delete walks up from pos
			k_q <= (in_func == psl_pkg::FN_INSERT) ? psl_pkg::IDX_W'(cnt_m1)
				: psl_pkg::IDX_W'(position);
		end else if (cmd.step) begin
			k_q <= (func_q == psl_pkg::FN_INSERT) ? k_q - psl_pkg::IDX_W'(1)
				: k_q + psl_pkg::IDX_W'(1);
		end
	end

	assign st.in_func  = in_func;
	assign st.in_ok    = in_ok;
	assign st.in_shift = in_shift;
	assign st.req_func = func_q;
	assign st.last     = (func_q == psl_pkg::FN_INSERT) ? (k_q == pos_idx_q)
		: (k_q == psl_pkg::IDX_W'(cnt_m1));
	assign st.out_free = !out_valid_q || !out_stall;

	// Memory: one read, one write per cycle; read data registered
	assign rd_en   = cmd.get_read || cmd.step;
	assign rd_addr = cmd.get_read ? psl_pkg::IDX_W'(pos_m1) : k_q;

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= entries_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpend_s1 <= 1'b0;
		end else begin
			wpend_s1 <= cmd.step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			waddr_s1 <= (func_q == psl_pkg::FN_INSERT) ? k_q + psl_pkg::IDX_W'(1)
				: k_q - psl_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wpend_s1)
			entries_q[waddr_s1] <= rdata_q;
		else if (cmd.write_val)
			entries_q[pos_idx_q] <= val_q;
	end

	// Count after the request
	always_comb begin
		count_d = count_q;
		unique case (func_q)
			psl_pkg::FN_INSERT: if (ok_req_q) count_d = count_q + psl_pkg::CNT_W'(1);
			psl_pkg::FN_DELETE: if (ok_req_q) count_d = cnt_m1;
			psl_pkg::FN_CLEAR:  count_d = '0;
			default:            count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				count_q <= count_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ok_q     <= ok_req_q;
			length_q <= psl_pkg::LEN_W'(count_d);
			if (func_q == psl_pkg::FN_GET && ok_req_q)
				read_value_q <= pos_zero_q ? psl_pkg::DATA_W'(count_q) : rdata_q;
			else
				read_value_q <= '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign read_value = read_value_q;
	assign length     = length_q;

endmodule

/* hw/rtl/psl_checker.sv */
// Port checker for the positional list top level, with its bind.
`include "assert_macros.svh"

module psl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              ok,
	input logic signed [psl_pkg::DATA_W-1:0] read_value,
	input logic [psl_pkg::LEN_W-1:0]         length
);

	// result beat held while stalled
	`PSL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
	`PSL_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(read_value) && $stable(length) && $stable(ok), "stalled result changed")
	// one request in flight: an accepted beat blocks the input next cycle
	`PSL_ASSERT_NEXT(a_one_inflight, in_valid && !in_stall, in_stall, "input taken while busy")
	`PSL_ASSERT(a_fail_zero, out_valid && !ok |-> read_value == '0, "failed request returned data")
	`PSL_ASSERT(a_len_cap, out_valid |-> 32'(length) <= psl_pkg::CAPACITY, "length above capacity")

endmodule

bind positional_sequence_list_top psl_checker u_psl_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for the positional list: random handshake traffic against a shadow list.
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT_CYCLES = 300000;
	localparam int HOLD_CYCLES  = 250;
	localparam int SETTLE       = 100;

	typedef struct packed {
		psl_pkg::func_t                 fn;
		logic [psl_pkg::POS_W-1:0]      pos;
		logic [psl_pkg::DATA_W-1:0]     val;
	} req_t;

	typedef struct packed {
		logic                           ok;
		logic [psl_pkg::DATA_W-1:0]     rd;
		logic [psl_pkg::LEN_W-1:0]      len;
	} reply_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [1:0]                        func = psl_pkg::FN_GET;
	logic [psl_pkg::POS_W-1:0]         position = '0;
	logic signed [psl_pkg::DATA_W-1:0] value = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic                              ok;
	logic signed [psl_pkg::DATA_W-1:0] read_value;
	logic [psl_pkg::LEN_W-1:0]         length;

	positional_sequence_list_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.read_value (read_value),
		.length     (length)
	);

	req_t   pending_reqs[$];
	reply_t due_replies[$];

	// shadow copy of the list, advanced on every accepted request
	logic [psl_pkg::DATA_W-1:0] shadow_list [psl_pkg::CAPACITY];
	int shadow_len = 0;
	// list length as seen by the stimulus generator
	int plan_len = 0;

	int send_gap_pct = 0;
	int rsp_gap_pct = 0;
	logic hold_go = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	int n_err = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_rejected = 0;
	int n_full_rejects = 0;
	int peak_len = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR %0t: %s: got %0h, expected %0h", $time, what, got, want);
		n_err++;
	endtask

	function automatic reply_t list_apply(input req_t r);
		reply_t res;
		int k;
		res = '0;
		case (r.fn)
			psl_pkg::FN_GET: begin
				if (r.pos == 0) begin
					res.ok = 1'b1;
					res.rd = 32'(shadow_len);
				end else if (r.pos <= shadow_len && r.pos <= psl_pkg::CAPACITY) begin
					res.ok = 1'b1;
					res.rd = shadow_list[r.pos - 1];
				end
			end
			psl_pkg::FN_INSERT: begin
				if (r.pos >= 1 && r.pos <= shadow_len + 1
						&& shadow_len < psl_pkg::CAPACITY) begin
					for (k = shadow_len; k > r.pos - 1; k--)
						shadow_list[k] = shadow_list[k - 1];
					shadow_list[r.pos - 1] = r.val;
					shadow_len++;
					res.ok = 1'b1;
				end
			end
			psl_pkg::FN_DELETE: begin
				if (r.pos >= 1 && r.pos <= shadow_len) begin
					for (k = r.pos - 1; k + 1 < shadow_len; k++)
						shadow_list[k] = shadow_list[k + 1];
					shadow_len--;
					res.ok = 1'b1;
				end
			end
			default: begin
				shadow_len = 0;
				res.ok = 1'b1;
			end
		endcase
		res.len = psl_pkg::LEN_W'(shadow_len);
		return res;
	endfunction

	task automatic push_req(input psl_pkg::func_t f, input int p, input logic [31:0] v);
		req_t r;
		r.fn = f;
		r.pos = psl_pkg::POS_W'(p);
		r.val = v;
		pending_reqs.push_back(r);
		case (f)
			psl_pkg::FN_INSERT:
				if (p >= 1 && p <= plan_len + 1 && plan_len < psl_pkg::CAPACITY)
					plan_len++;
			psl_pkg::FN_DELETE: if (p >= 1 && p <= plan_len) plan_len--;
			psl_pkg::FN_CLEAR:  plan_len = 0;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 2) return 32'h0000_0000;
		if (sel < 4) return 32'h7FFF_FFFF;
		if (sel < 6) return 32'h8000_0000;
		if (sel < 8) return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	// mostly in-range positions on a growing list, with edges and raw noise mixed in
	task automatic add_random(input int n);
		int i;
		int sel;
		int p;
		psl_pkg::func_t f;
		for (i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 42)
				f = psl_pkg::FN_INSERT;
			else if (sel < 70)
				f = psl_pkg::FN_DELETE;
			else if (sel < 98)
				f = psl_pkg::FN_GET;
			else
				f = psl_pkg::FN_CLEAR;
			sel = $urandom_range(99);
			if (sel < 10)
				p = $urandom_range(127);
			else if (sel < 16)
				p = (f == psl_pkg::FN_INSERT) ? plan_len + 1 : plan_len;
			else if (sel < 20)
				p = 0;
			else if (f == psl_pkg::FN_INSERT)
				p = $urandom_range(plan_len + 1, 1);
			else if (f == psl_pkg::FN_CLEAR || plan_len == 0)
				p = $urandom_range(127);
			else
				p = $urandom_range(plan_len, 1);
			push_req(f, p, pick_value());
		end
	endtask

	task automatic fill_list();
		while (plan_len < psl_pkg::CAPACITY)
			push_req(psl_pkg::FN_INSERT, $urandom_range(plan_len + 1, 1), pick_value());
		push_req(psl_pkg::FN_INSERT, 1, pick_value());
		push_req(psl_pkg::FN_INSERT, psl_pkg::CAPACITY + 1, pick_value());
		push_req(psl_pkg::FN_GET, psl_pkg::CAPACITY, '0);
		push_req(psl_pkg::FN_GET, psl_pkg::CAPACITY + 1, '0);
		push_req(psl_pkg::FN_GET, 0, '0);
		push_req(psl_pkg::FN_DELETE, psl_pkg::CAPACITY, '0);
		push_req(psl_pkg::FN_INSERT, psl_pkg::CAPACITY, 32'h8000_0000);
		push_req(psl_pkg::FN_GET, psl_pkg::CAPACITY, '0);
	endtask

	// a beat on the port but not yet accepted is still in flight
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || due_replies.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drv
		req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= psl_pkg::FN_GET;
			position <= '0;
			value <= '0;
		end else if (!in_valid || !in_stall) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				nxt = pending_reqs.pop_front();
				in_valid <= 1'b1;
				func <= nxt.fn;
				position <= nxt.pos;
				value <= nxt.val;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted on its own
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= (hold_left != 0) ||
				(rsp_gap_pct != 0 && $urandom_range(99) < rsp_gap_pct);
		end
	end

	// monitor: check result beats, then predict on request beats
	always @(posedge clk) begin : mon
		reply_t want;
		req_t got_req;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (due_replies.size() == 0) begin
					flag_mismatch("result with no request outstanding", read_value, '0);
				end else begin
					want = due_replies.pop_front();
					if (ok !== want.ok)
						flag_mismatch("ok", 32'(ok), 32'(want.ok));
					if (read_value !== want.rd)
						flag_mismatch("read_value", read_value, want.rd);
					if (length !== want.len)
						flag_mismatch("length", 32'(length), 32'(want.len));
				end
			end
			if (in_valid && !in_stall) begin
				got_req.fn = psl_pkg::func_t'(func);
				got_req.pos = position;
				got_req.val = value;
				if (got_req.fn == psl_pkg::FN_INSERT && shadow_len == psl_pkg::CAPACITY)
					n_full_rejects++;
				want = list_apply(got_req);
				if (!want.ok)
					n_rejected++;
				if (shadow_len > peak_len)
					peak_len = shadow_len;
				due_replies.push_back(want);
				n_sent++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				due_replies.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender idles a little, receiver a lot
		send_gap_pct <= 18;
		rsp_gap_pct <= 66;
		push_req(psl_pkg::FN_GET, 0, '0);
		push_req(psl_pkg::FN_GET, 1, '0);
		push_req(psl_pkg::FN_DELETE, 1, '0);
		push_req(psl_pkg::FN_CLEAR, 0, '0);
		push_req(psl_pkg::FN_INSERT, 0, 32'h1111_1111);
		push_req(psl_pkg::FN_INSERT, 2, 32'h2222_2222);
		push_req(psl_pkg::FN_INSERT, 1, 32'h7FFF_FFFF);
		push_req(psl_pkg::FN_INSERT, 1, 32'h8000_0000);
		push_req(psl_pkg::FN_INSERT, 3, 32'hFFFF_FFFF);
		push_req(psl_pkg::FN_INSERT, 2, 32'h0000_0000);
		push_req(psl_pkg::FN_INSERT, 127, 32'h1234_5678);
		push_req(psl_pkg::FN_GET, 0, '0);
		push_req(psl_pkg::FN_GET, 1, '0);
		push_req(psl_pkg::FN_GET, 2, '0);
		push_req(psl_pkg::FN_GET, 4, '0);
		push_req(psl_pkg::FN_GET, 5, '0);
		push_req(psl_pkg::FN_GET, 127, 32'hFFFF_FFFF);
		push_req(psl_pkg::FN_DELETE, 0, '0);
		push_req(psl_pkg::FN_DELETE, 5, '0);
		push_req(psl_pkg::FN_DELETE, 4, '0);
		push_req(psl_pkg::FN_DELETE, 1, '0);
		push_req(psl_pkg::FN_GET, 1, '0);
		push_req(psl_pkg::FN_CLEAR, 127, 32'hFFFF_FFFF);
		push_req(psl_pkg::FN_GET, 0, '0);
		add_random(110);
		wait_drained();

		// swapped: sender idles a lot, receiver a little
		send_gap_pct <= 66;
		rsp_gap_pct <= 18;
		fill_list();
		add_random(100);
		wait_drained();

		// no idling; the receiver holds off while requests keep coming
		send_gap_pct <= 0;
		rsp_gap_pct <= 0;
		add_random(100);
		@(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		wait_drained();

		repeat (SETTLE) @(negedge clk);
		while (due_replies.size() != 0) begin
			flag_mismatch("expected result never arrived", '0, due_replies[0].rd);
			void'(due_replies.pop_front());
		end

		$display("%0d requests, %0d results checked; %0d rejected, %0d into a full list",
			n_sent, n_checked, n_rejected, n_full_rejects);
		$display("peak list length %0d of %0d, %0d mismatches", peak_len,
			psl_pkg::CAPACITY, n_err);
		if (n_err == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
